// File: hdl/wfdc_pkg.sv
// Shared types and constants of the wall-follow drive controller.
package wfdc_pkg;

    localparam int DistWidth  = 11;
    localparam int DriveWidth = 13;
    localparam int SumWidth   = 14;
    localparam int IndexWidth = 3;

    typedef logic [DistWidth-1:0]  dist_t;
    typedef logic [DriveWidth-1:0] drive_t;
    typedef logic [SumWidth-1:0]   sum_t;
    typedef logic [IndexWidth-1:0] cfg_index_t;
    typedef logic [1:0]            action_t;

    // Action codes
    localparam action_t ACT_FORWARD    = 2'd0;
    localparam action_t ACT_SPIN_RIGHT = 2'd1;
    localparam action_t ACT_SPIN_LEFT  = 2'd2;
    localparam action_t ACT_OBSTACLE   = 2'd3;

    // Register indexes
    localparam cfg_index_t REG_TARGET_DISTANCE    = 3'd0;
    localparam cfg_index_t REG_CENTER_LIMIT       = 3'd1;
    localparam cfg_index_t REG_LEFT_LIMIT         = 3'd2;
    localparam cfg_index_t REG_RIGHT_LIMIT        = 3'd3;
    localparam cfg_index_t REG_LEFT_TRACK_ENABLE  = 3'd4;
    localparam cfg_index_t REG_RIGHT_TRACK_ENABLE = 3'd5;
    localparam cfg_index_t REG_MIN_DRIVE          = 3'd6;
    localparam cfg_index_t REG_MAX_DRIVE          = 3'd7;

    // Register reset values
    localparam dist_t  RST_TARGET_DISTANCE = 11'd160;
    localparam dist_t  RST_CENTER_LIMIT    = 11'd110;
    localparam dist_t  RST_LEFT_LIMIT      = 11'd10;
    localparam dist_t  RST_RIGHT_LIMIT     = 11'd10;
    localparam drive_t RST_MIN_DRIVE       = 13'd2500;
    localparam drive_t RST_MAX_DRIVE       = 13'd4500;

    localparam drive_t NOMINAL_LEVEL = 13'd3000;
    localparam drive_t SPIN_DUTY     = 13'd3000;
    localparam drive_t IMBALANCE     = 13'd300;
    localparam drive_t DRIVE_MAX     = 13'h1FFF;
    localparam logic signed [DistWidth:0] DEADBAND = 12'sd5;

endpackage

// File: hdl/wall_follow_drive_controller_core.sv
// Wall-follow drive controller: sample averaging, obstacle/spin checks, deadband tracking.
// Path: a request that completes a group of SAMPLES_PER_UPDATE samples passes through the
// sum register, the average register and the result register; a stalled output holds them.
// Throughput: one request per cycle while in_ready is high; one result per group.
// The average stage is a reciprocal multiply, one multiplier for each channel.
// Reset: asynchronous, active low; sums and count clear, both drive levels go to 3000,
// configuration registers take their default values and all pipeline stages empty.
module wall_follow_drive_controller_core #(
    parameter int SAMPLES_PER_UPDATE = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  wfdc_pkg::cfg_index_t        cfg_index,
    input  wfdc_pkg::drive_t            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  wfdc_pkg::dist_t             center_distance,
    input  wfdc_pkg::dist_t             left_distance,
    input  wfdc_pkg::dist_t             right_distance,
    output logic                        out_valid,
    input  logic                        out_ready,
    output wfdc_pkg::action_t           action,
    output wfdc_pkg::drive_t            left_duty,
    output wfdc_pkg::drive_t            right_duty
);
    import wfdc_pkg::*;

    localparam logic [2:0] FireCount = 3'(SAMPLES_PER_UPDATE % 8);
    localparam int         DivShift  = 17;
    localparam int         MultWidth = DivShift + 1;
    localparam int         ProdWidth = SumWidth + MultWidth;
    localparam logic [MultWidth-1:0] DivMult =
        MultWidth'((2 ** DivShift + SAMPLES_PER_UPDATE - 1) / SAMPLES_PER_UPDATE);

    // Configuration registers
    dist_t  target_reg, center_limit_reg, left_limit_reg, right_limit_reg;
    logic   left_en_reg, right_en_reg;
    drive_t min_drive_reg, max_drive_reg;

    // Accumulation
    logic [2:0] count_reg, count_next, count_inc;
    sum_t       c_sum_reg, l_sum_reg, r_sum_reg;
    sum_t       c_sum_next, l_sum_next, r_sum_next;
    sum_t       c_total, l_total, r_total;
    logic       fire, accept;

    // Stage 1: completed sums
    logic s1_valid_reg, s1_valid_next;
    sum_t s1_c_reg, s1_l_reg, s1_r_reg;

    // Stage 2: averages
    logic  s2_valid_reg, s2_valid_next;
    dist_t avg_c_reg, avg_l_reg, avg_r_reg;
    logic [ProdWidth-1:0] prod_c, prod_l, prod_r;

    // Levels and result
    drive_t  left_level_reg, right_level_reg, left_level_next, right_level_next;
    logic    out_valid_reg, out_valid_next;
    action_t action_reg, action_next;
    drive_t  left_duty_reg, right_duty_reg, left_duty_next, right_duty_next;

    logic out_move, s2_move, s1_move;

    // Decision terms
    logic signed [DistWidth:0] err_l, err_r;
    logic out_band_l, out_band_r;
    drive_t new_left, new_right;
    logic [DriveWidth:0] rd_sum;

    function automatic drive_t clamp_level(input drive_t level,
                                           input logic signed [DistWidth:0] err,
                                           input drive_t lo, input drive_t hi);
        logic signed [DriveWidth+1:0] v;
        logic signed [DriveWidth+1:0] r;
        v = $signed({2'b00, level}) + $signed({{3{err[DistWidth]}}, err});
        r = v;
        if (v > $signed({2'b00, hi}))
        begin
            r = $signed({2'b00, hi});
        end
        if (r < $signed({2'b00, lo}))
        begin
            r = $signed({2'b00, lo});
        end
        return r[DriveWidth-1:0];
    endfunction

    assign out_move = !out_valid_reg || out_ready;
    assign s2_move  = !s2_valid_reg || out_move;
    assign s1_move  = !s1_valid_reg || s2_move;
    assign in_ready = s1_move;
    assign accept   = in_valid && in_ready;

    assign count_inc = count_reg + 3'd1;
    assign fire      = (count_inc == FireCount);
    assign c_total   = c_sum_reg + SumWidth'(center_distance);
    assign l_total   = l_sum_reg + SumWidth'(left_distance);
    assign r_total   = r_sum_reg + SumWidth'(right_distance);

    // Divide by the group size through a reciprocal multiply
    assign prod_c = ProdWidth'(s1_c_reg) * ProdWidth'(DivMult);
    assign prod_l = ProdWidth'(s1_l_reg) * ProdWidth'(DivMult);
    assign prod_r = ProdWidth'(s1_r_reg) * ProdWidth'(DivMult);

    always_comb
    begin
        count_next = count_reg;
        c_sum_next = c_sum_reg;
        l_sum_next = l_sum_reg;
        r_sum_next = r_sum_reg;
        if (accept)
        begin
            if (fire)
            begin
                count_next = '0;
                c_sum_next = '0;
                l_sum_next = '0;
                r_sum_next = '0;
            end
            else
            begin
                count_next = count_inc;
                c_sum_next = c_total;
                l_sum_next = l_total;
                r_sum_next = r_total;
            end
        end
    end

    always_comb
    begin
        if (accept && fire)
        begin
            s1_valid_next = 1'b1;
        end
        else
        begin
            s1_valid_next = s1_valid_reg && !s2_move;
        end
        s2_valid_next  = s2_move ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_move ? s2_valid_reg : out_valid_reg;
    end

    // Decision on the averages
    always_comb
    begin
        err_l = $signed({1'b0, target_reg}) - $signed({1'b0, avg_l_reg});
        err_r = $signed({1'b0, target_reg}) - $signed({1'b0, avg_r_reg});
        out_band_l = (err_l >= DEADBAND) || (err_l <= -DEADBAND);
        out_band_r = (err_r >= DEADBAND) || (err_r <= -DEADBAND);

        new_left  = left_level_reg;
        new_right = right_level_reg;
        if (out_band_l && left_en_reg)
        begin
            new_left = clamp_level(left_level_reg, err_l, min_drive_reg, max_drive_reg);
        end
        else if (out_band_r && right_en_reg)
        begin
            new_right = clamp_level(right_level_reg, err_r, min_drive_reg, max_drive_reg);
        end
        else
        begin
            new_right = left_level_reg;
        end
        rd_sum = {1'b0, new_left} + {1'b0, IMBALANCE};

        left_level_next  = left_level_reg;
        right_level_next = right_level_reg;
        action_next      = action_reg;
        left_duty_next   = left_duty_reg;
        right_duty_next  = right_duty_reg;
        if (out_move && s2_valid_reg)
        begin
            priority if (avg_c_reg < center_limit_reg)
            begin
                left_level_next  = NOMINAL_LEVEL;
                right_level_next = NOMINAL_LEVEL;
                action_next      = ACT_OBSTACLE;
                left_duty_next   = '0;
                right_duty_next  = '0;
            end
            else if (avg_l_reg < left_limit_reg)
            begin
                action_next     = ACT_SPIN_RIGHT;
                left_duty_next  = SPIN_DUTY;
                right_duty_next = SPIN_DUTY;
            end
            else if (avg_r_reg < right_limit_reg)
            begin
                action_next     = ACT_SPIN_LEFT;
                left_duty_next  = SPIN_DUTY;
                right_duty_next = SPIN_DUTY;
            end
            else
            begin
                left_level_next  = new_left;
                right_level_next = new_right;
                action_next      = ACT_FORWARD;
                left_duty_next   = (new_right >= IMBALANCE) ? new_right - IMBALANCE : '0;
                right_duty_next  = rd_sum[DriveWidth] ? DRIVE_MAX : rd_sum[DriveWidth-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= RST_TARGET_DISTANCE;
            center_limit_reg <= RST_CENTER_LIMIT;
            left_limit_reg   <= RST_LEFT_LIMIT;
            right_limit_reg  <= RST_RIGHT_LIMIT;
            left_en_reg      <= 1'b1;
            right_en_reg     <= 1'b1;
            min_drive_reg    <= RST_MIN_DRIVE;
            max_drive_reg    <= RST_MAX_DRIVE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_DISTANCE:    target_reg       <= cfg_data[DistWidth-1:0];
                REG_CENTER_LIMIT:       center_limit_reg <= cfg_data[DistWidth-1:0];
                REG_LEFT_LIMIT:         left_limit_reg   <= cfg_data[DistWidth-1:0];
                REG_RIGHT_LIMIT:        right_limit_reg  <= cfg_data[DistWidth-1:0];
                REG_LEFT_TRACK_ENABLE:  left_en_reg      <= cfg_data[0];
                REG_RIGHT_TRACK_ENABLE: right_en_reg     <= cfg_data[0];
                REG_MIN_DRIVE:          min_drive_reg    <= cfg_data;
                REG_MAX_DRIVE:          max_drive_reg    <= cfg_data;
                default:                target_reg       <= target_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            c_sum_reg       <= '0;
            l_sum_reg       <= '0;
            r_sum_reg       <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            left_level_reg  <= NOMINAL_LEVEL;
            right_level_reg <= NOMINAL_LEVEL;
        end
        else
        begin
            count_reg       <= count_next;
            c_sum_reg       <= c_sum_next;
            l_sum_reg       <= l_sum_next;
            r_sum_reg       <= r_sum_next;
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
            out_valid_reg   <= out_valid_next;
            left_level_reg  <= left_level_next;
            right_level_reg <= right_level_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept && fire)
        begin
            s1_c_reg <= c_total;
            s1_l_reg <= l_total;
            s1_r_reg <= r_total;
        end
        if (s2_move)
        begin
            avg_c_reg <= prod_c[DivShift +: DistWidth];
            avg_l_reg <= prod_l[DivShift +: DistWidth];
            avg_r_reg <= prod_r[DivShift +: DistWidth];
        end
        action_reg     <= action_next;
        left_duty_reg  <= left_duty_next;
        right_duty_reg <= right_duty_next;
    end

    assign out_valid  = out_valid_reg;
    assign action     = action_reg;
    assign left_duty  = left_duty_reg;
    assign right_duty = right_duty_reg;

endmodule

// File: hdl/wfdc_checker.sv
// Port-level checks of the drive controller result channel, bound to the top level.
module wfdc_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  wfdc_pkg::action_t   action,
    input  wfdc_pkg::drive_t    left_duty,
    input  wfdc_pkg::drive_t    right_duty
);
    import wfdc_pkg::*;

    // Hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(left_duty)
            && $stable(right_duty))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_OBSTACLE |-> left_duty == '0 && right_duty == '0)
        else $error("obstacle result with nonzero duty");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_SPIN_LEFT || action == ACT_SPIN_RIGHT)
            |-> left_duty == SPIN_DUTY && right_duty == SPIN_DUTY)
        else $error("spin result with wrong duty");

    // Forward: right duty carries the imbalance, left duty never exceeds full level minus it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_FORWARD
            |-> right_duty >= IMBALANCE && left_duty <= DRIVE_MAX - IMBALANCE)
        else $error("forward duty out of range");

endmodule

bind wall_follow_drive_controller_core wfdc_checker u_wfdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .action     (action),
    .left_duty  (left_duty),
    .right_duty (right_duty)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the wall-follow drive controller core.
module testbench;
    import wfdc_pkg::*;

    localparam int GroupSize = 5;
    localparam int DistMax   = (1 << DistWidth) - 1;
    localparam int PhaseLen  = 100;
    localparam int Phases    = 10;

    typedef struct packed {
        action_t action;
        drive_t  left_duty;
        drive_t  right_duty;
    } update_t;

    // Tracks averaging, drive levels and register state; holds the pending updates.
    class drive_scoreboard;
        dist_t      target, center_lim, left_lim, right_lim;
        logic       left_en, right_en;
        drive_t     min_drive, max_drive;
        logic [2:0] count;
        sum_t       center_sum, left_sum, right_sum;
        drive_t     left_level, right_level;
        update_t    updates[$];
        int         mismatches, checked, requests;
        int         action_hits[4];

        function new();
            target      = RST_TARGET_DISTANCE;
            center_lim  = RST_CENTER_LIMIT;
            left_lim    = RST_LEFT_LIMIT;
            right_lim   = RST_RIGHT_LIMIT;
            left_en     = 1'b1;
            right_en    = 1'b1;
            min_drive   = RST_MIN_DRIVE;
            max_drive   = RST_MAX_DRIVE;
            count       = '0;
            center_sum  = '0;
            left_sum    = '0;
            right_sum   = '0;
            left_level  = NOMINAL_LEVEL;
            right_level = NOMINAL_LEVEL;
            mismatches  = 0;
            checked     = 0;
            requests    = 0;
            foreach (action_hits[i])
                action_hits[i] = 0;
        endfunction

        function void set_reg(cfg_index_t idx, drive_t data);
            case (idx)
                REG_TARGET_DISTANCE:    target = data[DistWidth-1:0];
                REG_CENTER_LIMIT:       center_lim = data[DistWidth-1:0];
                REG_LEFT_LIMIT:         left_lim = data[DistWidth-1:0];
                REG_RIGHT_LIMIT:        right_lim = data[DistWidth-1:0];
                REG_LEFT_TRACK_ENABLE:  left_en = data[0];
                REG_RIGHT_TRACK_ENABLE: right_en = data[0];
                REG_MIN_DRIVE:          min_drive = data;
                REG_MAX_DRIVE:          max_drive = data;
                default: ;
            endcase
        endfunction

        // Upper clamp first, lower clamp last: inverted limits settle on min_drive.
        function drive_t steer(drive_t level, int err);
            int v;
            v = int'(level) + err;
            if (v > int'(max_drive))
                v = int'(max_drive);
            if (v < int'(min_drive))
                v = int'(min_drive);
            return drive_t'(v);
        endfunction

        function void note_request(dist_t c, dist_t l, dist_t r);
            int      avg_c, avg_l, avg_r, err_l, err_r, duty;
            update_t u;
            requests++;
            center_sum = center_sum + c;
            left_sum   = left_sum + l;
            right_sum  = right_sum + r;
            count      = count + 3'd1;
            if (count != 3'(GroupSize))
                return;
            avg_c      = int'(center_sum) / GroupSize;
            avg_l      = int'(left_sum) / GroupSize;
            avg_r      = int'(right_sum) / GroupSize;
            center_sum = '0;
            left_sum   = '0;
            right_sum  = '0;
            count      = '0;
            if (avg_c < int'(center_lim))
            begin
                left_level   = NOMINAL_LEVEL;
                right_level  = NOMINAL_LEVEL;
                u.action     = ACT_OBSTACLE;
                u.left_duty  = '0;
                u.right_duty = '0;
            end
            else if (avg_l < int'(left_lim))
            begin
                u.action     = ACT_SPIN_RIGHT;
                u.left_duty  = SPIN_DUTY;
                u.right_duty = SPIN_DUTY;
            end
            else if (avg_r < int'(right_lim))
            begin
                u.action     = ACT_SPIN_LEFT;
                u.left_duty  = SPIN_DUTY;
                u.right_duty = SPIN_DUTY;
            end
            else
            begin
                err_l = int'(target) - avg_l;
                err_r = int'(target) - avg_r;
                if (left_en && (err_l >= int'(DEADBAND) || err_l <= -int'(DEADBAND)))
                    left_level = steer(left_level, err_l);
                else if (right_en && (err_r >= int'(DEADBAND) || err_r <= -int'(DEADBAND)))
                    right_level = steer(right_level, err_r);
                else
                    right_level = left_level;
                u.action     = ACT_FORWARD;
                duty         = int'(right_level) - int'(IMBALANCE);
                u.left_duty  = (duty < 0) ? drive_t'(0) : drive_t'(duty);
                duty         = int'(left_level) + int'(IMBALANCE);
                u.right_duty = (duty > int'(DRIVE_MAX)) ? DRIVE_MAX : drive_t'(duty);
            end
            updates.push_back(u);
        endfunction

        function void check_result(action_t a, drive_t ld, drive_t rd);
            update_t want;
            if (updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected update action=%0d left=%0d right=%0d",
                             a, ld, rd);
                return;
            end
            want = updates.pop_front();
            checked++;
            action_hits[want.action]++;
            if (a !== want.action || ld !== want.left_duty || rd !== want.right_duty)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: update %0d expected action=%0d left=%0d right=%0d,",
                             checked, want.action, want.left_duty, want.right_duty);
                    $display("       got action=%0d left=%0d right=%0d", a, ld, rd);
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    cfg_index_t cfg_index = '0;
    drive_t     cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    dist_t      center_distance = '0;
    dist_t      left_distance = '0;
    dist_t      right_distance = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    action_t    action;
    drive_t     left_duty;
    drive_t     right_duty;

    logic            steady = 1'b0;
    int              settings = 0;
    drive_scoreboard sb;

    wall_follow_drive_controller_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .center_distance (center_distance),
        .left_distance   (left_distance),
        .right_distance  (right_distance),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .action          (action),
        .left_duty       (left_duty),
        .right_duty      (right_duty)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 13);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(action, left_duty, right_duty);

    task automatic send_request(dist_t c, dist_t l, dist_t r);
        while (!steady && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        center_distance <= c;
        left_distance   <= l;
        right_distance  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(c, l, r);
    endtask

    // Drop the request line, then wait out every pending update and the pipeline.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.updates.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_one(cfg_index_t idx, drive_t data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(drive_t tgt, drive_t c_lim, drive_t l_lim, drive_t r_lim,
                                drive_t l_en, drive_t r_en, drive_t lo, drive_t hi);
        write_one(REG_TARGET_DISTANCE, tgt);
        write_one(REG_CENTER_LIMIT, c_lim);
        write_one(REG_LEFT_LIMIT, l_lim);
        write_one(REG_RIGHT_LIMIT, r_lim);
        write_one(REG_LEFT_TRACK_ENABLE, l_en);
        write_one(REG_RIGHT_TRACK_ENABLE, r_en);
        write_one(REG_MIN_DRIVE, lo);
        write_one(REG_MAX_DRIVE, hi);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    // Random junk in the bits above an 11-bit register; the block must drop it.
    function automatic drive_t with_junk(int value);
        drive_t d;
        d = drive_t'($urandom_range(0, int'(DRIVE_MAX)));
        d[DistWidth-1:0] = dist_t'(value);
        return d;
    endfunction

    function automatic drive_t enable_word(logic on);
        drive_t d;
        d = drive_t'($urandom_range(0, int'(DRIVE_MAX)));
        d[0] = on;
        return d;
    endfunction

    function automatic dist_t near(int base, int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > DistMax)
            v = DistMax;
        return dist_t'(v);
    endfunction

    // Half the time land inside the deadband, otherwise anywhere up to 80 either side of the target.
    function automatic int wall_offset();
        if ($urandom_range(0, 1) == 1)
            return int'($urandom_range(0, 8)) - 4;
        return int'($urandom_range(0, 160)) - 80;
    endfunction

    task automatic random_group();
        int pick, c_base, l_base, r_base;
        pick   = $urandom_range(0, 99);
        c_base = int'(sb.center_lim) + 200;
        l_base = int'(sb.target) + wall_offset();
        r_base = int'(sb.target) + wall_offset();
        if (pick < 10)
        begin
            // noise: a random-length run that can also break group alignment
            repeat ($urandom_range(1, GroupSize))
                send_request(dist_t'($urandom_range(0, DistMax)),
                             dist_t'($urandom_range(0, DistMax)),
                             dist_t'($urandom_range(0, DistMax)));
            return;
        end
        if (pick < 20)
            c_base = int'(sb.center_lim) - 20;
        else if (pick < 25)
            l_base = int'(sb.left_lim);
        else if (pick < 30)
            r_base = int'(sb.right_lim);
        repeat (GroupSize)
            send_request(near(c_base, 15), near(l_base, 3), near(r_base, 3));
    endtask

    initial
    begin
        drive_t lo, hi, swap;
        int     goal;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: obstacle, spin right, spin left
        repeat (GroupSize) send_request('0, '0, '0);
        repeat (GroupSize) send_request(11'd500, '0, dist_t'(DistMax));
        repeat (GroupSize) send_request(dist_t'(DistMax), 11'd500, '0);
        drain();

        // inverted drive limits: lower clamp wins, right duty saturates high
        program_regs(DRIVE_MAX, 13'h1800, 13'h1800, 13'h1800, 13'h0003, 13'h0001,
                     DRIVE_MAX, 13'd0);
        repeat (GroupSize) send_request(11'd500, '0, 11'd500);
        drain();

        // right tracking to a zero level saturates left duty; then deadband copy
        program_regs(DRIVE_MAX, 13'h1800, 13'h1800, 13'h1800, 13'h1FFE, 13'h0001,
                     13'd0, 13'd0);
        repeat (GroupSize) send_request(11'd500, 11'd500, '0);
        repeat (GroupSize) send_request(11'd500, dist_t'(DistMax), dist_t'(DistMax));

        for (int phase = 0; phase < Phases; phase++)
        begin
            drain();
            case (phase)
                0: program_regs(with_junk(0), with_junk(0), with_junk(0), with_junk(0),
                                enable_word(1'b1), enable_word(1'b1), 13'd300, 13'd7000);
                1: program_regs(with_junk(DistMax), with_junk(DistMax), with_junk(DistMax),
                                with_junk(DistMax), enable_word(1'b1), enable_word(1'b0),
                                13'd7000, 13'd300);
                default:
                begin
                    lo = drive_t'($urandom_range(300, 7000));
                    hi = drive_t'($urandom_range(300, 7000));
                    // keep most settings ordered, leave a few inverted
                    if (lo > hi && $urandom_range(0, 3) != 0)
                    begin
                        swap = lo;
                        lo   = hi;
                        hi   = swap;
                    end
                    program_regs(with_junk($urandom_range(40, 400)),
                                 with_junk($urandom_range(0, 150)),
                                 with_junk($urandom_range(0, 60)),
                                 with_junk($urandom_range(0, 60)),
                                 enable_word($urandom_range(0, 3) != 0),
                                 enable_word($urandom_range(0, 3) != 0),
                                 lo, hi);
                end
            endcase
            steady <= (phase == 3 || phase == 4);
            goal = sb.requests + PhaseLen;
            while (sb.requests < goal)
                random_group();
        end
        drain();

        $display("Sent %0d distance samples, checked %0d drive updates over %0d settings",
                 sb.requests, sb.checked, settings);
        $display("Updates: forward %0d, spin right %0d, spin left %0d, obstacle %0d",
                 sb.action_hits[ACT_FORWARD], sb.action_hits[ACT_SPIN_RIGHT],
                 sb.action_hits[ACT_SPIN_LEFT], sb.action_hits[ACT_OBSTACLE]);
        if (sb.mismatches == 0 && sb.updates.size() == 0)
            $display("** wall_follow_drive_controller_core: PASSED **");
        else
            $display("** wall_follow_drive_controller_core: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("ERROR: timeout with %0d updates pending", sb.updates.size());
        $display("** wall_follow_drive_controller_core: FAILED **");
        $finish;
    end

endmodule
